// ===== rtl/safr_pkg.sv =====
// ----------------------------------------------------------------------------
// safr_pkg
// Shared types and constants of the FIFO-reuse slot allocator.
// ----------------------------------------------------------------------------
package safr_pkg;

  localparam int SLOTS        = 256;
  localparam int PAYLOAD_BITS = 32;
  localparam int SLOT_W       = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int COUNT_W      = $clog2(SLOTS + 1);

  // function codes; code 3 decodes as a read
  localparam logic [1:0] FN_ALLOC = 2'd0;
  localparam logic [1:0] FN_FREE  = 2'd1;
  localparam logic [1:0] FN_READ  = 2'd2;

  localparam logic [2:0] ST_ALLOC      = 3'd0;
  localparam logic [2:0] ST_FREED      = 3'd1;
  localparam logic [2:0] ST_FREE_IGN   = 3'd2;
  localparam logic [2:0] ST_READ_OK    = 3'd3;
  localparam logic [2:0] ST_READ_EMPTY = 3'd4;
  localparam logic [2:0] ST_FULL       = 3'd5;

  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  slot_index;
    logic [31:0] entry_data;
  } req_t;

  typedef struct packed {
    logic [7:0]  granted_slot;
    logic [31:0] read_data;
    logic        slot_occupied;
    logic [2:0]  status;
  } rsp_t;

  // controller to datapath commands
  typedef struct packed {
    logic capture;
    logic fetch;
    logic exec;
  } cmd_t;

endpackage

// ===== rtl/slot_allocator_fifo_reuse_top.sv =====
// ----------------------------------------------------------------------------
// slot_allocator_fifo_reuse_top
// Handle table with a FIFO free list: allocate, free and read slots.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low. Each one passes
// through capture, the registered read of the payload store and free queue,
// and the state update; the result then appears with done for one cycle,
// while busy is already low so the next transaction can be taken in that
// same cycle. The receiver cannot stall: sample rsp whenever done is high.
// The occupancy map is cleared by reset at once, no sweep.
module slot_allocator_fifo_reuse_top import safr_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  req_t req,
  output logic done,
  output rsp_t rsp
);

  cmd_t cmd;

  safr_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  safr_datapath u_datapath (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .req  (req),
    .done (done),
    .rsp  (rsp)
  );

endmodule

// ===== rtl/safr_ctrl.sv =====
// ----------------------------------------------------------------------------
// safr_ctrl
// Sequencer: capture request, fetch from the stores, execute and respond.
// ----------------------------------------------------------------------------
module safr_ctrl import safr_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  output cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_FETCH,
    S_EXEC
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    case (state)
      S_IDLE:  state_next = (start && !busy) ? S_FETCH : S_IDLE;
      S_FETCH: state_next = S_EXEC;
      S_EXEC:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
    end else begin
      state <= state_next;
      busy  <= (state_next != S_IDLE);
    end
  end

  assign cmd.capture = start && !busy;
  assign cmd.fetch   = (state == S_FETCH);
  assign cmd.exec    = (state == S_EXEC);

endmodule

// ===== rtl/safr_datapath.sv =====
// ----------------------------------------------------------------------------
// safr_datapath
// Occupancy map, payload store, free queue and the result register.
// ----------------------------------------------------------------------------
module safr_datapath import safr_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  cmd_t cmd,
  input  req_t req,
  output logic done,
  output rsp_t rsp
);

  req_t                    req_q;
  logic [SLOTS-1:0]        occ_map;
  logic [SLOT_W-1:0]       head;
  logic [SLOT_W-1:0]       tail;
  logic [COUNT_W-1:0]      count;
  logic [COUNT_W-1:0]      high_water;
  logic [PAYLOAD_BITS-1:0] payload_mem [SLOTS];
  logic [SLOT_W-1:0]       queue_mem [SLOTS];
  logic [PAYLOAD_BITS-1:0] rd_payload;
  logic [SLOT_W-1:0]       rd_queue;

  logic              idx_valid;
  logic [SLOT_W-1:0] idx_addr;
  logic              idx_occ;
  logic              is_alloc;
  logic              is_free;
  logic              from_queue;
  logic              from_fresh;
  logic [SLOT_W-1:0] alloc_slot;
  logic              do_alloc;
  logic              do_free;
  logic              do_push;
  rsp_t              rsp_next;

  assign idx_valid = COUNT_W'(req_q.slot_index) < COUNT_W'(SLOTS);
  assign idx_addr  = SLOT_W'(req_q.slot_index);
  assign idx_occ   = idx_valid && occ_map[idx_addr];
  assign is_alloc  = (req_q.func == FN_ALLOC);
  assign is_free   = (req_q.func == FN_FREE);

  assign from_queue = (count != '0);
  assign from_fresh = !from_queue && (high_water < COUNT_W'(SLOTS));
  assign alloc_slot = from_queue ? rd_queue : high_water[SLOT_W-1:0];

  assign do_alloc = cmd.exec && is_alloc && (from_queue || from_fresh);
  assign do_free  = cmd.exec && is_free && idx_occ;
  assign do_push  = do_free && (count < COUNT_W'(SLOTS));

  always_comb begin
    rsp_next = '0;
    if (is_alloc) begin
      if (from_queue || from_fresh) begin
        rsp_next.granted_slot  = 8'(alloc_slot);
        rsp_next.slot_occupied = occ_map[alloc_slot];
        rsp_next.status        = ST_ALLOC;
      end else begin
        rsp_next.status = ST_FULL;
      end
    end else if (is_free) begin
      rsp_next.granted_slot  = req_q.slot_index;
      rsp_next.slot_occupied = idx_occ;
      rsp_next.status        = idx_occ ? ST_FREED : ST_FREE_IGN;
    end else begin
      rsp_next.granted_slot  = req_q.slot_index;
      rsp_next.slot_occupied = idx_occ;
      if (idx_occ) begin
        rsp_next.read_data = 32'(rd_payload);
        rsp_next.status    = ST_READ_OK;
      end else begin
        rsp_next.status = ST_READ_EMPTY;
      end
    end
  end

  // request and result registers
  always_ff @(posedge clk) begin
    if (cmd.capture) req_q <= req;
    if (cmd.exec)    rsp   <= rsp_next;
  end

  // stores: registered reads in the fetch cycle, writes in the execute cycle
  always_ff @(posedge clk) begin
    if (cmd.fetch) begin
      rd_payload <= payload_mem[idx_addr];
      rd_queue   <= queue_mem[head];
    end
    if (do_alloc) payload_mem[alloc_slot] <= PAYLOAD_BITS'(req_q.entry_data);
    if (do_push)  queue_mem[tail] <= idx_addr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done       <= 1'b0;
      occ_map    <= '0;
      head       <= '0;
      tail       <= '0;
      count      <= '0;
      high_water <= '0;
    end else begin
      done <= cmd.exec;
      if (do_alloc) begin
        occ_map[alloc_slot] <= 1'b1;
        if (from_queue) begin
          head  <= (head == SLOT_W'(SLOTS - 1)) ? '0 : head + 1'b1;
          count <= count - 1'b1;
        end else begin
          high_water <= high_water + 1'b1;
        end
      end
      if (do_free) occ_map[idx_addr] <= 1'b0;
      if (do_push) begin
        tail  <= (tail == SLOT_W'(SLOTS - 1)) ? '0 : tail + 1'b1;
        count <= count + 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  // every queued slot was handed out once, so the queue never outgrows it
  a_count_le_hw: assert property (@(posedge clk) disable iff (rst)
    count <= high_water)
    else $error("free queue holds more slots than were ever used");

  a_hw_bound: assert property (@(posedge clk) disable iff (rst)
    high_water <= COUNT_W'(SLOTS))
    else $error("high-water count beyond slot count");

  a_done_after_exec: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(cmd.exec))
    else $error("result strobe without an execute cycle");

  a_alloc_sets_occ: assert property (@(posedge clk) disable iff (rst)
    do_alloc |=> occ_map[$past(alloc_slot)])
    else $error("allocated slot not marked occupied");
`endif

endmodule

// ===== dv/tb_slot_allocator_fifo_reuse_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_slot_allocator_fifo_reuse_top
// Self-checking bench for the FIFO-reuse slot allocator. A short directed
// table covers empty reads and frees, both payload extremes, the alias read
// code and slot reuse. Random phases then fill the table to full, drain it
// and mix all operations. Every result is checked against an internal
// handle-table predictor.
// ----------------------------------------------------------------------------
module tb_slot_allocator_fifo_reuse_top;
  import safr_pkg::*;

  localparam logic [1:0] FN_READ_ALT = 2'd3;  // decodes as a read
  localparam int ITEMS       = 1100;
  localparam int STALL_LIMIT = 2000;
  localparam int TAIL_CYCLES = 12;
  localparam int IDLE_PCT    = 21;

  typedef struct packed {
    req_t stim;
    bit   typed;
    rsp_t want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst;
  logic start;
  logic busy;
  req_t req;
  logic done;
  rsp_t rsp;

  slot_allocator_fifo_reuse_top dut (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .busy (busy),
    .req  (req),
    .done (done),
    .rsp  (rsp)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // handle table state as predicted
  bit [SLOTS-1:0] occ_map;
  logic [31:0]    payload_mem [SLOTS];
  logic [7:0]     reuse_fifo [SLOTS];
  logic [7:0]     reuse_head;
  logic [7:0]     reuse_tail;
  int             reuse_cnt;
  int             fresh_mark;

  // expected results in order of acceptance
  rsp_t       pending_rsp [16];
  logic [3:0] pend_head;
  logic [3:0] pend_tail;
  int         pend_cnt;

  int   err_count;
  int   sent;
  int   stall_cycles;
  bit   idle_en;
  int   n_alloc, n_reuse, n_freed, n_reads, n_full;

  dir_row_t dir_table [19] = '{
    '{'{FN_READ,     8'd0,   32'h0},        1'b1, '{8'd0,   32'h0,        1'b0, ST_READ_EMPTY}},
    '{'{FN_FREE,     8'd255, 32'hFFFFFFFF}, 1'b1, '{8'd255, 32'h0,        1'b0, ST_FREE_IGN}},
    '{'{FN_READ_ALT, 8'd128, 32'h0},        1'b1, '{8'd128, 32'h0,        1'b0, ST_READ_EMPTY}},
    '{'{FN_ALLOC,    8'd255, 32'h0},        1'b1, '{8'd0,   32'h0,        1'b0, ST_ALLOC}},
    '{'{FN_ALLOC,    8'd0,   32'hFFFFFFFF}, 1'b1, '{8'd1,   32'h0,        1'b0, ST_ALLOC}},
    '{'{FN_ALLOC,    8'd170, 32'hA5A55A5A}, 1'b1, '{8'd2,   32'h0,        1'b0, ST_ALLOC}},
    '{'{FN_READ,     8'd1,   32'h0},        1'b1, '{8'd1,   32'hFFFFFFFF, 1'b1, ST_READ_OK}},
    '{'{FN_READ,     8'd0,   32'hFFFFFFFF}, 1'b1, '{8'd0,   32'h0,        1'b1, ST_READ_OK}},
    '{'{FN_READ_ALT, 8'd2,   32'h0},        1'b1, '{8'd2,   32'hA5A55A5A, 1'b1, ST_READ_OK}},
    '{'{FN_FREE,     8'd1,   32'h0},        1'b1, '{8'd1,   32'h0,        1'b1, ST_FREED}},
    '{'{FN_FREE,     8'd1,   32'h0},        1'b1, '{8'd1,   32'h0,        1'b0, ST_FREE_IGN}},
    '{'{FN_READ,     8'd1,   32'h0},        1'b1, '{8'd1,   32'h0,        1'b0, ST_READ_EMPTY}},
    '{'{FN_FREE,     8'd0,   32'h0},        1'b1, '{8'd0,   32'h0,        1'b1, ST_FREED}},
    // reuse order: slot 1 first, then slot 0, then a fresh slot
    '{'{FN_ALLOC,    8'd85,  32'h12345678}, 1'b0, '0},
    '{'{FN_ALLOC,    8'd0,   32'h89ABCDEF}, 1'b0, '0},
    '{'{FN_ALLOC,    8'd0,   32'h0F0F0F0F}, 1'b0, '0},
    '{'{FN_READ,     8'd1,   32'h0},        1'b0, '0},
    '{'{FN_READ,     8'd3,   32'h0},        1'b0, '0},
    '{'{FN_READ,     8'd255, 32'h0},        1'b1, '{8'd255, 32'h0,        1'b0, ST_READ_EMPTY}}
  };

  function automatic rsp_t handle_table_next(req_t r);
    rsp_t       o;
    logic [7:0] s;
    bit         was;
    o = '0;
    was = occ_map[r.slot_index];
    o.granted_slot = r.slot_index;
    case (r.func)
      FN_ALLOC: begin
        o.granted_slot = 8'd0;
        if (reuse_cnt != 0 || fresh_mark < SLOTS) begin
          if (reuse_cnt != 0) begin
            s = reuse_fifo[reuse_head];
            reuse_head++;
            reuse_cnt--;
            n_reuse++;
          end else begin
            s = fresh_mark[7:0];
            fresh_mark++;
          end
          o.granted_slot  = s;
          o.slot_occupied = occ_map[s];
          occ_map[s]      = 1'b1;
          payload_mem[s]  = r.entry_data;
          o.status        = ST_ALLOC;
          n_alloc++;
        end else begin
          o.status = ST_FULL;
          n_full++;
        end
      end
      FN_FREE: begin
        if (was) begin
          occ_map[r.slot_index]  = 1'b0;
          reuse_fifo[reuse_tail] = r.slot_index;
          reuse_tail++;
          reuse_cnt++;
          o.slot_occupied = 1'b1;
          o.status        = ST_FREED;
          n_freed++;
        end else begin
          o.status = ST_FREE_IGN;
        end
      end
      default: begin
        n_reads++;
        if (was) begin
          o.read_data     = payload_mem[r.slot_index];
          o.slot_occupied = 1'b1;
          o.status        = ST_READ_OK;
        end else begin
          o.status = ST_READ_EMPTY;
        end
      end
    endcase
    return o;
  endfunction

  // mostly an occupied slot, so frees and reads hit live handles
  function automatic logic [7:0] pick_slot(int occ_pct);
    logic [7:0] s;
    s = 8'($urandom_range(255, 0));
    if ($urandom_range(99, 0) < occ_pct && occ_map != '0) begin
      while (!occ_map[s]) s++;
    end
    return s;
  endfunction

  function automatic req_t rand_req(int alloc_pct, int free_pct, int occ_pct);
    req_t r;
    int   roll;
    roll = $urandom_range(99, 0);
    r.entry_data = $urandom;
    r.slot_index = 8'($urandom_range(255, 0));
    if (roll < alloc_pct) begin
      r.func = FN_ALLOC;
    end else if (roll < alloc_pct + free_pct) begin
      r.func       = FN_FREE;
      r.slot_index = pick_slot(occ_pct);
    end else begin
      r.func       = ($urandom_range(3, 0) == 0) ? FN_READ_ALT : FN_READ;
      r.slot_index = pick_slot(occ_pct);
    end
    return r;
  endfunction

  task automatic issue(input req_t r, input bit typed, input rsp_t want);
    rsp_t pred;
    int   gap;
    @(negedge clk);
    if (idle_en && $urandom_range(99, 0) < IDLE_PCT) begin
      start <= 1'b0;
      gap = $urandom_range(6, 1);
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    req   <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    pred = handle_table_next(r);
    pending_rsp[pend_tail] = typed ? want : pred;
    pend_tail++;
    pend_cnt++;
    sent++;
  endtask

  task automatic wait_quiet();
    @(negedge clk);
    start <= 1'b0;
    while (pend_cnt != 0) @(posedge clk);
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    err_count++;
    if (err_count <= 40)
      $display("[%0t] %s: got %0h, want %0h", $time, what, got, want);
  endtask

  // result checker and progress watchdog
  always @(posedge clk) begin
    rsp_t want;
    if (!rst) begin
      if ((start && !busy) || done) stall_cycles = 0;
      else stall_cycles++;
      if (done) begin
        if (pend_cnt == 0) begin
          report_mismatch("result with no transaction pending", rsp, 0);
        end else begin
          want = pending_rsp[pend_head];
          pend_head++;
          pend_cnt--;
          if (rsp.granted_slot !== want.granted_slot)
            report_mismatch("granted_slot", rsp.granted_slot, want.granted_slot);
          if (rsp.read_data !== want.read_data)
            report_mismatch("read_data", rsp.read_data, want.read_data);
          if (rsp.slot_occupied !== want.slot_occupied)
            report_mismatch("slot_occupied", rsp.slot_occupied, want.slot_occupied);
          if (rsp.status !== want.status)
            report_mismatch("status", rsp.status, want.status);
        end
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("no progress for %0d cycles, %0d results outstanding",
                 stall_cycles, pend_cnt);
        $display("tb_slot_allocator_fifo_reuse_top: errors");
        $finish;
      end
    end
  end

  initial begin
    int phase;
    int full_mark;
    rst          = 1'b1;
    start        = 1'b0;
    req          = '0;
    occ_map      = '0;
    reuse_head   = '0;
    reuse_tail   = '0;
    reuse_cnt    = 0;
    pend_head    = '0;
    pend_tail    = '0;
    pend_cnt     = 0;
    fresh_mark   = 0;
    err_count    = 0;
    sent         = 0;
    stall_cycles = 0;
    idle_en      = 1'b1;
    n_alloc = 0; n_reuse = 0; n_freed = 0; n_reads = 0; n_full = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_table[i])
      issue(dir_table[i].stim, dir_table[i].typed, dir_table[i].want);

    phase = 0;
    while (sent < ITEMS) begin
      idle_en = (phase != 2);  // one phase runs back to back
      case (phase % 3)
        0: begin
          // fill until the table refuses four more allocations
          full_mark = n_full + 4;
          while (n_full < full_mark) issue(rand_req(85, 5, 90), 1'b0, '0);
        end
        1: repeat ($urandom_range(260, 160)) issue(rand_req(10, 70, 85), 1'b0, '0);
        default: repeat ($urandom_range(200, 100)) issue(rand_req(35, 30, 75), 1'b0, '0);
      endcase
      // after odd phases, hold the sender off until the block has answered everything
      if (phase % 2 == 1) wait_quiet();
      phase++;
    end

    wait_quiet();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("%0d transactions: %0d allocations (%0d from the free queue), %0d frees,",
             sent, n_alloc, n_reuse, n_freed);
    $display("%0d reads, %0d allocations refused as full", n_reads, n_full);
    if (err_count == 0) begin
      $display("tb_slot_allocator_fifo_reuse_top: clean");
    end else begin
      $display("tb_slot_allocator_fifo_reuse_top: errors");
    end
    $finish;
  end

endmodule
